FILE: src/itpt_pkg.sv
package itpt_pkg;

    localparam int MAX_FIELD = 64;
    localparam int OUT_LIMIT = (MAX_FIELD < 64) ? MAX_FIELD : 64;
    localparam int QDEPTH = 2;

    localparam logic [2:0] FUNC_SDEC = 3'd0;
    localparam logic [2:0] FUNC_UDEC = 3'd1;
    localparam logic [2:0] FUNC_OCT  = 3'd2;
    localparam logic [2:0] FUNC_LHEX = 3'd3;
    localparam logic [2:0] FUNC_UHEX = 3'd4;

    localparam logic [1:0] SIZE_H = 2'd1;
    localparam logic [1:0] SIZE_L = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] arg_value;
        logic [1:0]  size_mod;
        logic        left_justify;
        logic        force_sign;
        logic        space_sign;
        logic        alt_form;
        logic        zero_fill;
        logic [6:0]  field_width;
        logic        prec_given;
        logic [5:0]  min_digits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        logic [63:0] mag;
        logic [2:0]  func;
        logic        neg;
        logic        force_sign;
        logic        space_sign;
        logic        alt_form;
        logic        left_justify;
        logic        zero_fill;
        logic [6:0]  field_width;
        logic        prec_given;
        logic [5:0]  min_digits;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else if (upper) begin
            c = 8'h37 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

endpackage

FILE: src/itpt_front.sv
module itpt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itpt_pkg::in_item_t  s_item,
    output logic                job_valid,
    input  logic                job_ready,
    output itpt_pkg::job_t      job
);

    itpt_pkg::job_t q_reg [itpt_pkg::QDEPTH];
    logic [1:0] cnt_reg;
    logic       wptr_reg;
    logic       rptr_reg;
    itpt_pkg::job_t cls;
    logic [63:0] u;
    logic        sgn;
    logic        push;
    logic        pop;

    // Truncate, extend and take the magnitude
    always_comb begin
        cls = '0;
        unique case (s_item.size_mod)
            itpt_pkg::SIZE_H: begin
                u = {48'd0, s_item.arg_value[15:0]};
                sgn = s_item.arg_value[15];
            end
            itpt_pkg::SIZE_L: begin
                u = s_item.arg_value;
                sgn = s_item.arg_value[63];
            end
            default: begin
                u = {32'd0, s_item.arg_value[31:0]};
                sgn = s_item.arg_value[31];
            end
        endcase
        cls.neg = (s_item.func == itpt_pkg::FUNC_SDEC) && sgn;
        unique case (s_item.size_mod)
            itpt_pkg::SIZE_H: cls.mag = cls.neg ? {48'd0, 16'(-u[15:0])} : u;
            itpt_pkg::SIZE_L: cls.mag = cls.neg ? -u : u;
            default:          cls.mag = cls.neg ? {32'd0, 32'(-u[31:0])} : u;
        endcase
        cls.func = s_item.func;
        cls.force_sign = s_item.force_sign;
        cls.space_sign = s_item.space_sign;
        cls.alt_form = s_item.alt_form;
        cls.left_justify = s_item.left_justify;
        cls.zero_fill = s_item.zero_fill;
        cls.field_width = s_item.field_width;
        cls.prec_given = s_item.prec_given;
        cls.min_digits = s_item.min_digits;
    end

    // Drop unknown conversions at the front door
    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready && (s_item.func <= itpt_pkg::FUNC_UHEX);
    assign job_valid = (cnt_reg != 2'd0);
    assign pop = job_valid && job_ready;
    assign job = q_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: src/itpt_back.sv
module itpt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  itpt_pkg::job_t      job,
    output logic                m_valid,
    input  logic                m_ready,
    output itpt_pkg::out_item_t m_item
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BCD  = 5'b00010,
        ST_CONV = 5'b00100,
        ST_PLAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t      state_reg;
    itpt_pkg::job_t j_reg;
    logic [79:0] mag_reg;
    logic [63:0] bin_reg;
    logic [3:0]  bcnt_reg;
    logic [3:0]  dig_reg [24];
    logic [4:0]  nd_reg;
    logic [6:0]  zeros_reg, pad_reg;
    logic [1:0]  plen_reg;
    logic [7:0]  pre0_reg, pre1_reg;
    logic        zf_reg;
    logic [8:0]  pos_reg;
    logic [6:0]  lim_reg;
    logic [6:0]  sent_reg;
    logic        ov_reg;

    logic [79:0] bcd_c;
    logic [63:0] bin_c;
    logic        job_dec;
    logic [79:0] q_next;
    logic [3:0]  d_next;
    logic [6:0]  prec, zeros_c;
    logic [8:0]  body;
    logic [6:0]  pad_c;
    logic [1:0]  plen_c;
    logic [7:0]  p0, p1;
    logic [8:0]  tot_c;
    logic [7:0]  ch;
    logic [8:0]  r;
    logic [4:0]  di;
    logic        upper;
    logic        adv;

    assign job_dec = (job.func == itpt_pkg::FUNC_SDEC) || (job.func == itpt_pkg::FUNC_UDEC);

    // Convert binary to BCD four bits a cycle by add-three and shift
    always_comb begin
        bcd_c = mag_reg;
        bin_c = bin_reg;
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < 20; k++) begin
                if (bcd_c[4*k +: 4] >= 4'd5) bcd_c[4*k +: 4] = bcd_c[4*k +: 4] + 4'd3;
            end
            bcd_c = {bcd_c[78:0], bin_c[63]};
            bin_c = {bin_c[62:0], 1'b0};
        end
    end

    // One digit a cycle: peel off the low octal or hex digit, or the low BCD digit
    always_comb begin
        unique case (j_reg.func)
            itpt_pkg::FUNC_OCT: begin
                q_next = mag_reg >> 3;
                d_next = {1'b0, mag_reg[2:0]};
            end
            default: begin
                q_next = mag_reg >> 4;
                d_next = mag_reg[3:0];
            end
        endcase
    end

    // Work out the layout of the text
    always_comb begin
        prec = j_reg.prec_given ? {1'b0, j_reg.min_digits} : 7'd1;
        zeros_c = (prec > {2'b0, nd_reg}) ? prec - {2'b0, nd_reg} : 7'd0;
        plen_c = 2'd0;
        p0 = 8'h30;
        p1 = 8'h78;
        unique case (j_reg.func)
            itpt_pkg::FUNC_SDEC: begin
                if (j_reg.neg) begin
                    plen_c = 2'd1; p0 = 8'h2D;
                end else if (j_reg.force_sign) begin
                    plen_c = 2'd1; p0 = 8'h2B;
                end else if (j_reg.space_sign) begin
                    plen_c = 2'd1; p0 = 8'h20;
                end
            end
            itpt_pkg::FUNC_OCT: begin
                if (j_reg.alt_form && zeros_c == 7'd0 &&
                    (nd_reg == 5'd0 || dig_reg[nd_reg - 5'd1] != 4'd0)) plen_c = 2'd1;
            end
            itpt_pkg::FUNC_LHEX, itpt_pkg::FUNC_UHEX: begin
                if (j_reg.alt_form && j_reg.mag != 64'd0) plen_c = 2'd2;
                if (j_reg.func == itpt_pkg::FUNC_UHEX) p1 = 8'h58;
            end
            default: plen_c = 2'd0;
        endcase
        body = {7'd0, plen_c} + {2'd0, zeros_c} + {4'd0, nd_reg};
        pad_c = ({2'b0, j_reg.field_width} > body) ?
            7'({2'b0, j_reg.field_width} - body) : 7'd0;
        tot_c = body + {2'd0, pad_c};
    end

    // Pick the character at the current position
    always_comb begin
        upper = (j_reg.func == itpt_pkg::FUNC_UHEX);
        r = pos_reg;
        ch = 8'h20;
        di = 5'd0;
        if (!j_reg.left_justify && !zf_reg && r < {2'd0, pad_reg}) begin
            ch = 8'h20;
        end else begin
            if (!j_reg.left_justify && !zf_reg) r = r - {2'd0, pad_reg};
            if (r < {7'd0, plen_reg}) begin
                ch = (r == 9'd0) ? pre0_reg : pre1_reg;
            end else begin
                r = r - {7'd0, plen_reg};
                if (zf_reg && r < {2'd0, pad_reg}) begin
                    ch = 8'h30;
                end else begin
                    if (zf_reg) r = r - {2'd0, pad_reg};
                    if (r < {2'd0, zeros_reg}) begin
                        ch = 8'h30;
                    end else begin
                        r = r - {2'd0, zeros_reg};
                        if (r < {4'd0, nd_reg}) begin
                            di = 5'(nd_reg - 5'd1 - r[4:0]);
                            ch = itpt_pkg::digit_char(dig_reg[di], upper);
                        end else begin
                            ch = 8'h20;
                        end
                    end
                end
            end
        end
    end

    assign job_ready = (state_reg == ST_IDLE);
    assign adv = !ov_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && job_valid) begin
            j_reg <= job;
            bin_reg <= job.mag;
            mag_reg <= job_dec ? 80'd0 : {16'd0, job.mag};
        end
        if (state_reg == ST_BCD) begin
            mag_reg <= bcd_c;
            bin_reg <= bin_c;
        end
        if (state_reg == ST_CONV) begin
            mag_reg <= q_next;
            dig_reg[nd_reg] <= d_next;
        end
        if (state_reg == ST_PLAN) begin
            zeros_reg <= zeros_c;
            pad_reg <= pad_c;
            plen_reg <= plen_c;
            pre0_reg <= (j_reg.func == itpt_pkg::FUNC_SDEC) ? p0 : 8'h30;
            pre1_reg <= p1;
            zf_reg <= j_reg.zero_fill && !j_reg.left_justify && !j_reg.prec_given;
            lim_reg <= (tot_c > 9'(itpt_pkg::OUT_LIMIT)) ?
                7'(itpt_pkg::OUT_LIMIT) : 7'(tot_c);
        end
        if (state_reg == ST_EMIT && adv) begin
            m_item.out_char <= ch;
            m_item.last_char <= (sent_reg + 7'd1 == lim_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nd_reg <= 5'd0;
            bcnt_reg <= 4'd0;
            pos_reg <= 9'd0;
            sent_reg <= 7'd0;
            ov_reg <= 1'b0;
        end else begin
            // Load the output register on advance, drop it once taken
            if (state_reg == ST_EMIT && adv) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && m_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        nd_reg <= 5'd0;
                        bcnt_reg <= 4'd0;
                        state_reg <= job_dec ? ST_BCD : ST_CONV;
                    end
                end
                ST_BCD: begin
                    bcnt_reg <= bcnt_reg + 4'd1;
                    if (bcnt_reg == 4'd15) state_reg <= ST_CONV;
                end
                ST_CONV: begin
                    // Zero with precision zero keeps no digit
                    if (mag_reg == 80'd0 && nd_reg != 5'd0) begin
                        state_reg <= ST_PLAN;
                    end else if (mag_reg == 80'd0 && j_reg.prec_given &&
                                 j_reg.min_digits == 6'd0) begin
                        state_reg <= ST_PLAN;
                    end else begin
                        nd_reg <= nd_reg + 5'd1;
                    end
                end
                ST_PLAN: begin
                    pos_reg <= 9'd0;
                    sent_reg <= 7'd0;
                    state_reg <= (tot_c == 9'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    if (adv) begin
                        pos_reg <= pos_reg + 9'd1;
                        sent_reg <= sent_reg + 7'd1;
                        if (sent_reg + 7'd1 == lim_reg) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = ov_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (sent_reg < lim_reg))
        else $error("emit past limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (nd_reg <= 5'd22))
        else $error("too many digits");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !job_ready)
        else $error("job taken while busy");

endmodule

FILE: src/integer_to_padded_text.sv
// Channel | Ports                    | Moves
// input   | s_valid s_ready s_item   | one integer format request
// output  | m_valid m_ready m_item   | one character, last_char on the final one
// An item leaves the queue, then goes through binary-to-BCD conversion for the
// decimal forms, digit collection (up to 22 digits), layout, and then the emission
// of its characters (up to 64). A two-entry queue lets requests arrive meanwhile.
// Reset is synchronous, active low, and empties the queue.
// A stalled output holds the character and freezes the emit position.
module integer_to_padded_text (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itpt_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output itpt_pkg::out_item_t m_item
);

    logic           job_valid;
    logic           job_ready;
    itpt_pkg::job_t job;

    itpt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    itpt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 350;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    itpt_pkg::in_item_t  s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    itpt_pkg::out_item_t m_item;

    integer_to_padded_text i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    itpt_pkg::out_item_t char_queue[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        stim_done = 1'b0;
    bit        hold_off = 1'b0;
    bit        no_idle = 1'b0;

    // Format one request into the characters the block must emit
    function automatic void format_request(input itpt_pkg::in_item_t r);
        logic [63:0] mask, u, mag;
        logic [7:0]  dig[$];
        logic [7:0]  prefix[$];
        logic [7:0]  text[$];
        int          bits, base, nd, prec, zeros, body, pad, lim;
        bit          neg, zf;
        itpt_pkg::out_item_t o;
        if (r.func > itpt_pkg::FUNC_UHEX) return;
        bits = (r.size_mod == itpt_pkg::SIZE_H) ? 16 :
               (r.size_mod == itpt_pkg::SIZE_L) ? 64 : 32;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        u = r.arg_value & mask;
        mag = u;
        neg = 1'b0;
        if (r.func == itpt_pkg::FUNC_SDEC && u[bits-1]) begin
            neg = 1'b1;
            mag = (64'd0 - u) & mask;
        end
        base = (r.func <= itpt_pkg::FUNC_UDEC) ? 10 : (r.func == itpt_pkg::FUNC_OCT) ? 8 : 16;
        // digits collected least significant first
        if (mag == 0) begin
            if (!(r.prec_given && r.min_digits == 0)) dig.push_back("0");
        end else begin
            while (mag != 0) begin
                int d;
                d = int'(mag % base);
                if (d < 10) dig.push_back(8'(8'h30 + d));
                else if (r.func == itpt_pkg::FUNC_UHEX) dig.push_back(8'(8'h37 + d));
                else dig.push_back(8'(8'h57 + d));
                mag = mag / base;
            end
        end
        nd = dig.size();
        prec = r.prec_given ? int'(r.min_digits) : 1;
        zeros = (prec > nd) ? prec - nd : 0;
        if (r.func == itpt_pkg::FUNC_SDEC) begin
            if (neg) prefix.push_back("-");
            else if (r.force_sign) prefix.push_back("+");
            else if (r.space_sign) prefix.push_back(" ");
        end else if (r.func == itpt_pkg::FUNC_OCT) begin
            if (r.alt_form && zeros == 0 && (nd == 0 || dig[nd-1] != "0"))
                prefix.push_back("0");
        end else if (r.func != itpt_pkg::FUNC_UDEC) begin
            if (r.alt_form && u != 0) begin
                prefix.push_back("0");
                prefix.push_back(r.func == itpt_pkg::FUNC_UHEX ? "X" : "x");
            end
        end
        body = prefix.size() + zeros + nd;
        pad = (r.field_width > body) ? int'(r.field_width) - body : 0;
        zf = r.zero_fill && !r.left_justify && !r.prec_given;
        if (!r.left_justify && !zf) repeat (pad) text.push_back(" ");
        foreach (prefix[i]) text.push_back(prefix[i]);
        if (zf) repeat (pad) text.push_back("0");
        repeat (zeros) text.push_back("0");
        for (int k = nd - 1; k >= 0; k--) text.push_back(dig[k]);
        if (r.left_justify) repeat (pad) text.push_back(" ");
        lim = (text.size() < itpt_pkg::OUT_LIMIT) ? text.size() : itpt_pkg::OUT_LIMIT;
        for (int k = 0; k < lim; k++) begin
            o.out_char = text[k];
            o.last_char = (k + 1 == lim);
            char_queue.push_back(o);
        end
    endfunction

    // Directed rows: func, value, size, flags {left,plus,space,alt,zero}, width, pg, prec
    typedef struct {
        logic [2:0]  func;
        logic [63:0] val;
        logic [1:0]  sz;
        logic [4:0]  flags;
        logic [6:0]  fw;
        logic        pg;
        logic [5:0]  md;
        string       text;
    } row_t;

    row_t rows[] = '{
        '{itpt_pkg::FUNC_SDEC, 64'd0, 2'd0, 5'b00000, 7'd0, 1'b0, 6'd0, "0"},
        '{itpt_pkg::FUNC_SDEC, 64'hFFFF_FFFF, 2'd0, 5'b00000, 7'd0, 1'b0, 6'd0, "-1"},
        '{itpt_pkg::FUNC_SDEC, 64'h8000_0000, 2'd0, 5'b00000, 7'd0, 1'b0, 6'd0,
          "-2147483648"},
        '{itpt_pkg::FUNC_SDEC, 64'h8000, 2'd1, 5'b00000, 7'd0, 1'b0, 6'd0, "-32768"},
        '{itpt_pkg::FUNC_SDEC, 64'h8000_0000_0000_0000, 2'd2, 5'b00000, 7'd0, 1'b0, 6'd0,
          "-9223372036854775808"},
        '{itpt_pkg::FUNC_UDEC, '1, 2'd2, 5'b00000, 7'd0, 1'b0, 6'd0,
          "18446744073709551615"},
        '{itpt_pkg::FUNC_OCT, '1, 2'd2, 5'b00010, 7'd0, 1'b0, 6'd0,
          "01777777777777777777777"},
        '{itpt_pkg::FUNC_LHEX, 64'hABCD, 2'd3, 5'b00010, 7'd0, 1'b0, 6'd0, "0xabcd"},
        '{itpt_pkg::FUNC_UHEX, 64'hABCD, 2'd0, 5'b00010, 7'd0, 1'b0, 6'd0, "0XABCD"},
        '{itpt_pkg::FUNC_SDEC, 64'd5, 2'd0, 5'b01000, 7'd0, 1'b0, 6'd0, "+5"},
        '{itpt_pkg::FUNC_SDEC, 64'd5, 2'd0, 5'b00100, 7'd0, 1'b0, 6'd0, " 5"},
        '{itpt_pkg::FUNC_SDEC, 64'd5, 2'd0, 5'b01100, 7'd0, 1'b0, 6'd0, "+5"},
        '{itpt_pkg::FUNC_UDEC, 64'd5, 2'd0, 5'b01100, 7'd0, 1'b0, 6'd0, "5"},
        '{itpt_pkg::FUNC_SDEC, 64'd0, 2'd0, 5'b00000, 7'd0, 1'b1, 6'd0, ""},
        '{itpt_pkg::FUNC_OCT, 64'd0, 2'd0, 5'b00010, 7'd0, 1'b1, 6'd0, "0"},
        '{itpt_pkg::FUNC_OCT, 64'd8, 2'd0, 5'b00010, 7'd0, 1'b1, 6'd3, "010"},
        '{itpt_pkg::FUNC_LHEX, 64'd0, 2'd0, 5'b00010, 7'd4, 1'b0, 6'd0, "   0"},
        '{itpt_pkg::FUNC_SDEC, 64'hFFFF_FFF9, 2'd0, 5'b00001, 7'd6, 1'b0, 6'd0, "-00007"},
        '{itpt_pkg::FUNC_SDEC, 64'd7, 2'd0, 5'b00001, 7'd6, 1'b1, 6'd3, "   007"},
        '{itpt_pkg::FUNC_SDEC, 64'd7, 2'd0, 5'b10001, 7'd4, 1'b0, 6'd0, "7   "},
        '{3'd5, 64'd1, 2'd0, 5'b00000, 7'd10, 1'b0, 6'd0, ""},
        '{3'd7, 64'd1, 2'd0, 5'b00000, 7'd10, 1'b0, 6'd0, ""},
        '{itpt_pkg::FUNC_UDEC, 64'd1, 2'd0, 5'b00000, 7'd64, 1'b1, 6'd62, "?"},
        '{itpt_pkg::FUNC_UDEC, '1, 2'd2, 5'b11111, 7'd127, 1'b1, 6'd63, "?"}
    };

    function automatic itpt_pkg::in_item_t row_item(input row_t r);
        itpt_pkg::in_item_t t;
        t.func = r.func;
        t.arg_value = r.val;
        t.size_mod = r.sz;
        {t.left_justify, t.force_sign, t.space_sign, t.alt_form, t.zero_fill} = r.flags;
        t.field_width = r.fw;
        t.prec_given = r.pg;
        t.min_digits = r.md;
        return t;
    endfunction

    function automatic itpt_pkg::in_item_t random_request();
        itpt_pkg::in_item_t t;
        t.func = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0: t.arg_value = 64'($urandom_range(0, 20));
            1: t.arg_value = {32'hFFFF_FFFF, $urandom()};
            default: t.arg_value = {$urandom(), $urandom()};
        endcase
        t.size_mod = 2'($urandom_range(0, 3));
        {t.left_justify, t.force_sign, t.space_sign, t.alt_form, t.zero_fill} =
            5'($urandom());
        t.field_width = ($urandom_range(0, 9) == 0) ? 7'($urandom())
                                                     : 7'($urandom_range(0, 24));
        t.prec_given = 1'($urandom());
        t.min_digits = ($urandom_range(0, 9) == 0) ? 6'($urandom())
                                                    : 6'($urandom_range(0, 24));
        return t;
    endfunction

    // Offer one request and wait until it is taken; idle with valid low
    task automatic send_request(input itpt_pkg::in_item_t t, input bit predict);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 23) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item <= t;
        do @(posedge aclk); while (!s_ready);
        if (predict) format_request(t);
    endtask

    // Stimulus
    initial begin
        string exp_text;
        itpt_pkg::out_item_t o;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            exp_text = rows[i].text;
            if (exp_text != "?") begin
                // typed text is the expected output of the row
                for (int k = 0; k < exp_text.len(); k++) begin
                    o.out_char = exp_text[k];
                    o.last_char = (k + 1 == exp_text.len());
                    char_queue.push_back(o);
                end
                send_request(row_item(rows[i]), 1'b0);
            end else begin
                send_request(row_item(rows[i]), 1'b1);
            end
        end
        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle = (n >= 100 && n < 160);
            hold_off = (n >= 200 && n < 215);
            send_request(random_request(), 1'b1);
        end
        s_valid <= 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold_off && held < 600) begin
                m_ready <= 1'b0;
                held++;
            end else begin
                m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Compare each character against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (char_queue.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected char %h last %b", m_item.out_char, m_item.last_char);
                mismatch_count++;
            end else begin
                if (m_item !== char_queue[0]) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 char_queue[0].out_char, char_queue[0].last_char,
                                 m_item.out_char, m_item.last_char);
                    mismatch_count++;
                end
                void'(char_queue.pop_front());
            end
        end
    end

    // Watchdog and end of run
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout");
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done && char_queue.size() == 0) begin
                repeat (200) @(posedge aclk);
                if (mismatch_count == 0 && char_queue.size() == 0) begin
                    $display("CHECK OK");
                end else begin
                    $display("CHECK FAILED");
                end
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
src/itpt_pkg.sv
src/itpt_front.sv
src/itpt_back.sv
src/integer_to_padded_text.sv
sim/tb_top.sv
